// File: hw/rtl/tcps_pkg.sv
// Package for the code point record search block.
// Holds the channel transaction types, phase codes, result kinds and sizes.
// No dependencies.
`timescale 1ns / 1ps

package tcps_pkg;

   // Width of the running byte position; the counter wraps at this width
   localparam int POSITION_BITS = 16;

   // Record header: 4 length bytes then 2 code point bytes
   localparam int HDR_BYTES      = 6;
   localparam int LEN_BYTES      = 4;

   // Search phases
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_SKIP    = 3'd1;
   localparam logic [2:0] PH_HEADER  = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_PASS    = 3'd4;
   localparam logic [2:0] PH_DONE    = 3'd5;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_NONE    = 2'd2;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] buffer_length;
      logic [15:0] start_offset;
      logic [15:0] code_point;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_last;
      logic [1:0] result_kind;
   } rsp_type;

endpackage

// File: hw/rtl/tcps_engine.sv
// Search engine: per-buffer state registers and the single-pass update logic.
// One byte is consumed per step; a result is produced when emit is high.
// Depends on tcps_pkg.
`timescale 1ns / 1ps

module tcps_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  tcps_pkg::req_type item,
   output logic             emit,
   output tcps_pkg::rsp_type result
);
   import tcps_pkg::*;

   logic [2:0]               phase_ff, phase_in;
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [15:0]              total_ff, total_in;
   logic [15:0]              skip_ff, skip_in;
   logic [15:0]              wanted_ff, wanted_in;
   logic [2:0]               hdr_cnt_ff, hdr_cnt_in;
   logic [31:0]              rec_len_ff, rec_len_in;
   logic [15:0]              rec_point_ff, rec_point_in;
   logic [15:0]              left_ff, left_in;

   // Candidate start of the following record, from the current record
   logic [15:0]              next_skip;
   logic                     next_fail;
   logic [POSITION_BITS-1:0] pos_cur;
   logic [2:0]               hdr_cnt_inc;
   logic [15:0]              left_dec;

   assign next_skip = skip_ff + rec_len_ff[15:0];
   assign next_fail = ({1'b0, next_skip} + 17'(HDR_BYTES)) > {1'b0, total_ff};

   // Per-byte update
   always_comb begin
      phase_in     = phase_ff;
      position_in  = position_ff;
      total_in     = total_ff;
      skip_in      = skip_ff;
      wanted_in    = wanted_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      rec_len_in   = rec_len_ff;
      rec_point_in = rec_point_ff;
      left_in      = left_ff;
      emit         = 1'b0;
      result       = '0;
      pos_cur      = position_ff;
      hdr_cnt_inc  = '0;
      left_dec     = left_ff - 16'd1;

      // First byte of a buffer samples the buffer parameters
      if (phase_ff == PH_IDLE) begin
         total_in     = item.buffer_length;
         skip_in      = item.start_offset;
         wanted_in    = item.code_point;
         pos_cur      = '0;
         left_in      = '0;
         phase_in     = PH_SKIP;
         hdr_cnt_in   = '0;
         rec_len_in   = '0;
         rec_point_in = '0;
         if (({1'b0, item.start_offset} + 17'(HDR_BYTES)) > {1'b0, item.buffer_length}) begin
            phase_in           = PH_DONE;
            emit               = 1'b1;
            result.result_kind = KIND_NONE;
         end
      end

      if (phase_in == PH_SKIP && 32'(pos_cur) == 32'(skip_in)) begin
         phase_in = PH_HEADER;
      end

      if (!emit) begin
         unique case (phase_in)
            PH_HEADER: begin
               if (hdr_cnt_in < 3'(LEN_BYTES)) begin
                  rec_len_in = {rec_len_in[23:0], item.data_byte};
               end else begin
                  rec_point_in = {rec_point_in[7:0], item.data_byte};
               end
               hdr_cnt_inc = hdr_cnt_in + 3'd1;
               hdr_cnt_in  = hdr_cnt_inc;
               if (hdr_cnt_inc == 3'(LEN_BYTES)) begin
                  // Length too small or record runs past the buffer
                  if (rec_len_in < 32'(HDR_BYTES) ||
                      ({17'd0, skip_in} + {1'b0, rec_len_in}) > {17'd0, total_in}) begin
                     phase_in           = PH_DONE;
                     emit               = 1'b1;
                     result.result_kind = KIND_NONE;
                  end
               end else if (hdr_cnt_inc == 3'(HDR_BYTES)) begin
                  left_in = rec_len_in[15:0] - 16'(HDR_BYTES);
                  if (rec_point_in == wanted_in) begin
                     if (left_in == '0) begin
                        phase_in           = PH_DONE;
                        emit               = 1'b1;
                        result.result_kind = KIND_EMPTY;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end else if (left_in == '0) begin
                     // Empty record with another code point: move on
                     skip_in      = next_skip;
                     phase_in     = PH_HEADER;
                     hdr_cnt_in   = '0;
                     rec_len_in   = '0;
                     rec_point_in = '0;
                     if (next_fail) begin
                        phase_in           = PH_DONE;
                        emit               = 1'b1;
                        result.result_kind = KIND_NONE;
                     end
                  end else begin
                     phase_in = PH_PASS;
                  end
               end
            end
            PH_PAYLOAD: begin
               left_in             = left_dec;
               emit                = 1'b1;
               result.payload_byte = item.data_byte;
               result.result_kind  = KIND_PAYLOAD;
               if (left_dec == '0) begin
                  phase_in            = PH_DONE;
                  result.payload_last = 1'b1;
               end
            end
            PH_PASS: begin
               left_in = left_dec;
               if (left_dec == '0) begin
                  skip_in      = next_skip;
                  phase_in     = PH_HEADER;
                  hdr_cnt_in   = '0;
                  rec_len_in   = '0;
                  rec_point_in = '0;
                  if (next_fail) begin
                     phase_in           = PH_DONE;
                     emit               = 1'b1;
                     result.result_kind = KIND_NONE;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // End of buffer: the next byte opens a new one
      position_in = pos_cur + POSITION_BITS'(1);
      if (32'(position_in) >= 32'(total_in)) begin
         phase_in = PH_IDLE;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         position_ff <= '0;
         hdr_cnt_ff  <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         hdr_cnt_ff  <= hdr_cnt_in;
      end
   end

   // Buffer and record fields
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         skip_ff      <= '0;
         wanted_ff    <= '0;
         rec_len_ff   <= '0;
         rec_point_ff <= '0;
         left_ff      <= '0;
      end else if (step) begin
         total_ff     <= total_in;
         skip_ff      <= skip_in;
         wanted_ff    <= wanted_in;
         rec_len_ff   <= rec_len_in;
         rec_point_ff <= rec_point_in;
         left_ff      <= left_in;
      end
   end

endmodule

// File: hw/rtl/tlv_code_point_search.sv
// Top level of the code point record search: input register, engine, result register.
// Depends on tcps_pkg and tcps_engine.
`timescale 1ns / 1ps

// Channel   Direction  Transaction
// req_*     in         one buffer byte; first byte also brings length, offset, code point
// rsp_*     out        one payload byte, an empty-match flag or a no-match report
//
// Throughput is one byte per cycle unless a pending result stalls; the engine updates its state for one byte per step.
// rsp_valid rises once its byte has passed the input register and then the result register.
// Reset clears all control state; no memory, no clearing pass.
// A pending result stalls only bytes that would produce another result; other bytes
// keep flowing, and req_ready follows rsp_ready while such a byte is held.

module tlv_code_point_search (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcps_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcps_pkg::rsp_type rsp_payload
);
   import tcps_pkg::*;

   logic    in_valid_ff;
   req_type in_item_ff;
   logic    out_valid_ff;
   rsp_type out_item_ff;

   logic    emit;
   rsp_type result;
   logic    out_open;
   logic    step;

   // Byte is processed unless its result cannot be stored
   assign out_open  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && (!emit || out_open);
   assign req_ready = !in_valid_ff || step;

   tcps_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .emit   (emit),
      .result (result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule
